>>> sv/catmull_rom_spline_4lane_top_defines.svh
// Assertion macros for the Catmull-Rom spline evaluator.
// Included by the top level; empty bodies when SYNTHESIS is defined.
`ifndef CATMULL_ROM_SPLINE_4LANE_TOP_DEFINES_SVH
`define CATMULL_ROM_SPLINE_4LANE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define CRS_ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("%m: implication failed");
// Next-cycle implication.
`define CRS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("%m: next-cycle implication failed");
`else
`define CRS_ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define CRS_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

>>> sv/crs_pkg.sv
// Shared constants and types for the Catmull-Rom spline evaluator.
// No dependencies.
`default_nettype none
package crs_pkg;
	localparam int LANES_DEF     = 4;
	localparam int ELEM_BITS_DEF = 16;
	localparam int MAX_LANES     = 4;
	localparam int FIELD_W       = 64;
	localparam int IN_FIELDS     = 5;
	localparam int MASK_W        = 4;
	localparam int S_TDATA_W     = IN_FIELDS * FIELD_W;
	localparam int M_TDATA_W     = ((FIELD_W + MASK_W + 7) / 8) * 8;

	// Field order inside s_tdata.
	localparam int F_PARAM = 0;
	localparam int F_KNOT0 = 1;
	localparam int F_KNOT1 = 2;
	localparam int F_KNOT2 = 3;
	localparam int F_KNOT3 = 4;

	// Per-stage load enables of the lane pipeline and the merge register.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic merge;
	} pipe_en_t;
endpackage
`default_nettype wire

>>> sv/catmull_rom_spline_4lane_top.sv
// Four-lane Catmull-Rom spline evaluator, signed Q8.8 knots, Q1.15 parameter.
// Pipeline: m_tvalid rises once the input transaction has passed the five lane
// stages and the merge register.
// Throughput: one transaction per cycle while m_tready is high; each stage
// holds independently, so bubbles are squeezed out while the output is stalled.
// Reset clears the stage valid bits only; data registers are not reset.
// Depends on crs_pkg, crs_lane, crs_merge and the assertion macro header.
`default_nettype none
`include "catmull_rom_spline_4lane_top_defines.svh"
module catmull_rom_spline_4lane_top import crs_pkg::*; #(
	parameter int LANES        = LANES_DEF,
	parameter int ELEMENT_BITS = ELEM_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// param_lanes[63:0], knot0_lanes[127:64], knot1_lanes[191:128],
	// knot2_lanes[255:192], knot3_lanes[319:256]
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// curve_lanes[63:0], saturated_mask[67:64], zero[71:68]
	output logic      [M_TDATA_W-1:0] m_tdata
);
	localparam int E = ELEMENT_BITS;

	logic     v_s1, v_s2, v_s3, v_s4, v_s5, v_q;
	pipe_en_t en;

	// a stage loads when it is empty or its content moves on
	always_comb begin
		en.merge = !v_q  || m_tready;
		en.s5    = !v_s5 || en.merge;
		en.s4    = !v_s4 || en.s5;
		en.s3    = !v_s3 || en.s4;
		en.s2    = !v_s2 || en.s3;
		en.s1    = !v_s1 || en.s2;
	end

	assign s_tready = en.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_q  <= 1'b0;
		end else begin
			if (en.s1)    v_s1 <= s_tvalid;
			if (en.s2)    v_s2 <= v_s1;
			if (en.s3)    v_s3 <= v_s2;
			if (en.s4)    v_s4 <= v_s3;
			if (en.s5)    v_s5 <= v_s4;
			if (en.merge) v_q  <= v_s5;
		end
	end

	logic [LANES-1:0][E-1:0] lane_y;
	logic [LANES-1:0]        lane_sat;

	for (genvar gi = 0; gi < LANES; gi++) begin : g_lane
		crs_lane #(
			.ELEMENT_BITS(ELEMENT_BITS)
		) u_lane (
			.clk(clk),
			.en (en),
			.t  (s_tdata[F_PARAM*FIELD_W + gi*E +: E]),
			.k0 (s_tdata[F_KNOT0*FIELD_W + gi*E +: E]),
			.k1 (s_tdata[F_KNOT1*FIELD_W + gi*E +: E]),
			.k2 (s_tdata[F_KNOT2*FIELD_W + gi*E +: E]),
			.k3 (s_tdata[F_KNOT3*FIELD_W + gi*E +: E]),
			.y  (lane_y[gi]),
			.sat(lane_sat[gi])
		);
	end

	logic [FIELD_W-1:0] curve;
	logic [MASK_W-1:0]  mask;

	crs_merge #(
		.LANES       (LANES),
		.ELEMENT_BITS(ELEMENT_BITS)
	) u_merge (
		.clk     (clk),
		.en      (en),
		.lane_y  (lane_y),
		.lane_sat(lane_sat),
		.curve   (curve),
		.mask    (mask)
	);

	assign m_tvalid = v_q;
	assign m_tdata  = {{(M_TDATA_W - FIELD_W - MASK_W){1'b0}}, mask, curve};

	localparam logic [E-1:0] LANE_HI = {1'b0, {(E - 1){1'b1}}};
	localparam logic [E-1:0] LANE_LO = {1'b1, {(E - 1){1'b0}}};

	logic lane0_at_rail;
	assign lane0_at_rail = (curve[E-1:0] == LANE_HI) || (curve[E-1:0] == LANE_LO);

	`CRS_ASSERT_IMPLIES(a_empty_ready, clk, arst_n, !v_s1, s_tready)
	`CRS_ASSERT_NEXT(a_merge_fills, clk, arst_n, v_s5 && !m_tvalid, m_tvalid)
	`CRS_ASSERT_IMPLIES(a_clamp_bound, clk, arst_n, m_tvalid && mask[0], lane0_at_rail)
	`CRS_ASSERT_IMPLIES(a_unused_mask, clk, arst_n, m_tvalid, (mask >> LANES) == '0)
endmodule
`default_nettype wire

>>> sv/crs_lane.sv
// One spline lane: coefficients, Horner steps and round/saturate, five stages.
// Depends on crs_pkg for the stage enable struct.
`default_nettype none
module crs_lane import crs_pkg::*; #(
	parameter int ELEMENT_BITS = ELEM_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire pipe_en_t                       en,
	input  wire logic        [ELEMENT_BITS-1:0] t,
	input  wire logic signed [ELEMENT_BITS-1:0] k0,
	input  wire logic signed [ELEMENT_BITS-1:0] k1,
	input  wire logic signed [ELEMENT_BITS-1:0] k2,
	input  wire logic signed [ELEMENT_BITS-1:0] k3,
	output logic             [ELEMENT_BITS-1:0] y,
	output logic                                sat
);
	localparam int E   = ELEMENT_BITS;
	localparam int PF  = E - 1;
	localparam int AW  = E + 4;
	localparam int H1W = AW + E + 2;
	localparam int H2W = H1W + E + 2;
	localparam int QW  = H2W - 2 * PF;
	localparam int MW  = QW + E + 2;
	localparam int YW  = MW - PF - 1;
	localparam logic signed [MW-1:0] RND  = {{(MW - PF - 1){1'b0}}, 1'b1, {PF{1'b0}}};
	localparam logic signed [YW-1:0] Y_HI = {{(YW - E + 1){1'b0}}, {(E - 1){1'b1}}};
	localparam logic signed [YW-1:0] Y_LO = ~Y_HI;

	// stage 1: doubled coefficients
	logic signed [AW-1:0] k0x, k1x, k2x, k3x, a3_c, a2_c, a1_c;
	logic signed [AW-1:0] a3_s1, a2_s1, a1_s1;
	logic signed [E-1:0]  k1_s1;
	logic        [E-1:0]  t_s1;

	assign k0x  = AW'(k0);
	assign k1x  = AW'(k1);
	assign k2x  = AW'(k2);
	assign k3x  = AW'(k3);
	assign a3_c = k3x - k0x + (k1x + (k1x <<< 1)) - (k2x + (k2x <<< 1));
	assign a2_c = (k0x <<< 1) - ((k1x <<< 2) + k1x) + (k2x <<< 2) - k3x;
	assign a1_c = k2x - k0x;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			a3_s1 <= a3_c;
			a2_s1 <= a2_c;
			a1_s1 <= a1_c;
			k1_s1 <= k1;
			t_s1  <= t;
		end
	end

	// stage 2: h1 = a3*t + a2*2^PF
	logic signed [E:0]      tx1;
	logic signed [AW+E:0]   p2_c;
	logic signed [H1W-1:0]  h1_s2;
	logic signed [AW-1:0]   a1_s2;
	logic signed [E-1:0]    k1_s2;
	logic        [E-1:0]    t_s2;

	assign tx1  = $signed({1'b0, t_s1});
	assign p2_c = a3_s1 * tx1;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			h1_s2 <= H1W'(p2_c) + (H1W'(a2_s1) <<< PF);
			a1_s2 <= a1_s1;
			k1_s2 <= k1_s1;
			t_s2  <= t_s1;
		end
	end

	// stage 3: h2 = h1*t + a1*2^(2PF)
	logic signed [E:0]      tx2;
	logic signed [H1W+E:0]  p3_c;
	logic signed [H2W-1:0]  h2_s3;
	logic signed [E-1:0]    k1_s3;
	logic        [E-1:0]    t_s3;

	assign tx2  = $signed({1'b0, t_s2});
	assign p3_c = h1_s2 * tx2;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			h2_s3 <= H2W'(p3_c) + (H2W'(a1_s2) <<< (2 * PF));
			k1_s3 <= k1_s2;
			t_s3  <= t_s2;
		end
	end

	// stage 4: split h2 into floor quotient and remainder, multiply both by t
	logic signed [E:0]          tx3;
	logic signed [QW-1:0]       q_c;
	logic        [2*PF-1:0]     r_c;
	logic signed [QW+E:0]       qt_c;
	logic        [2*PF+E-1:0]   rt_c;
	logic signed [QW+E:0]       qt_s4;
	logic        [E-1:0]        rtf_s4;
	logic signed [E-1:0]        k1_s4;

	assign tx3  = $signed({1'b0, t_s3});
	assign q_c  = $signed(h2_s3[H2W-1:2*PF]);
	assign r_c  = h2_s3[2*PF-1:0];
	assign qt_c = q_c * tx3;
	assign rt_c = r_c * t_s3;

	always_ff @(posedge clk) begin
		if (en.s4) begin
			qt_s4  <= qt_c;
			rtf_s4 <= rt_c[2*PF+E-1:2*PF];
			k1_s4  <= k1_s3;
		end
	end

	// stage 5: add k1 and rounding bias, floor, clamp
	logic signed [MW-1:0] m_c;
	logic signed [YW-1:0] yf_c;
	logic        [E-1:0]  y_s5;
	logic                 sat_s5;

	assign m_c  = MW'(qt_s4) + (MW'(k1_s4) <<< (PF + 1)) + RND
		+ MW'($signed({1'b0, rtf_s4}));
	assign yf_c = $signed(m_c[MW-1:PF+1]);

	always_ff @(posedge clk) begin
		if (en.s5) begin
			priority if (yf_c > Y_HI) begin
				y_s5   <= Y_HI[E-1:0];
				sat_s5 <= 1'b1;
			end else if (yf_c < Y_LO) begin
				y_s5   <= Y_LO[E-1:0];
				sat_s5 <= 1'b1;
			end else begin
				y_s5   <= yf_c[E-1:0];
				sat_s5 <= 1'b0;
			end
		end
	end

	assign y   = y_s5;
	assign sat = sat_s5;
endmodule
`default_nettype wire

>>> sv/crs_merge.sv
// Merge stage: packs lane values and clamp flags into the output register.
// Depends on crs_pkg for widths and the stage enable struct.
`default_nettype none
module crs_merge import crs_pkg::*; #(
	parameter int LANES        = LANES_DEF,
	parameter int ELEMENT_BITS = ELEM_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire pipe_en_t                           en,
	input  wire logic [LANES-1:0][ELEMENT_BITS-1:0] lane_y,
	input  wire logic [LANES-1:0]                   lane_sat,
	output logic      [FIELD_W-1:0]                 curve,
	output logic      [MASK_W-1:0]                  mask
);
	logic [FIELD_W-1:0] curve_c, curve_q;
	logic [MASK_W-1:0]  mask_c, mask_q;

	// unused lanes stay zero
	always_comb begin
		curve_c = '0;
		mask_c  = '0;
		for (int i = 0; i < LANES; i++) begin
			curve_c[i*ELEMENT_BITS +: ELEMENT_BITS] = lane_y[i];
			mask_c[i]                               = lane_sat[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en.merge) begin
			curve_q <= curve_c;
			mask_q  <= mask_c;
		end
	end

	assign curve = curve_q;
	assign mask  = mask_q;
endmodule
`default_nettype wire
